### sv/assert_macros.svh
// Assertion macros used by the alarm clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is held.
`define ACBS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acbs assertion failed");
// Clocked check that also holds during reset.
`define ACBS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("acbs assertion failed");
`else
`define ACBS_ASSERT(lbl, clk, rst_n, prop)
`define ACBS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### sv/acbs_pkg.sv
// Types, constants and the alarm check function of the alarm clock block.
package acbs_pkg;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_BUTTONS = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLOCK     = 2'd0,
    MODE_MENU      = 2'd1,
    MODE_SET_ALARM = 2'd2,
    MODE_SET_TIME  = 2'd3
  } mode_t;

  localparam logic [1:0] FIELD_HOURS   = 2'd0;
  localparam logic [1:0] FIELD_MINUTES = 2'd1;
  localparam logic [1:0] FIELD_SECONDS = 2'd2;
  localparam logic [1:0] FIELD_NONE    = 2'd3;

  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] HOUR_LIM = 6'd24;
  localparam logic [5:0] MIN_LIM  = 6'd60;
  localparam logic [5:0] SEC_LIM  = 6'd60;

  localparam logic [7:0] RING_SECONDS_RESET = 8'd10;

  typedef struct packed {
    logic command;
    logic btn_mode;
    logic btn_accept;
    logic btn_up;
    logic btn_down;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [5:0] alarm_seconds;
    logic [1:0] ui_mode;
    logic       menu_index;
    logic [1:0] edit_field;
    logic       alarm_on;
    logic       ringing;
  } out_item_t;

  // Rings if enabled, unguarded, h and m >= alarm's, and s >= alarm's or m > alarm's.
  function automatic logic alarm_active(
    input logic       en,
    input logic       guard,
    input logic [4:0] h,
    input logic [5:0] m,
    input logic [5:0] s,
    input logic [4:0] al_h,
    input logic [5:0] al_m,
    input logic [5:0] al_s
  );
    return en && !guard && (h >= al_h) && (m >= al_m) && ((s >= al_s) || (m > al_m));
  endfunction

endpackage

### sv/acbs_in_stage.sv
// Input register stage of the alarm clock block.
module acbs_in_stage import acbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     vld,
  output in_item_t item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     acc;

  assign in_stall = vld_r && !take;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_data;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

### sv/acbs_core.sv
// Clock, alarm and menu state with the per-beat update logic.
`include "assert_macros.svh"

module acbs_core import acbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output out_item_t snap_nxt
);

  localparam int BTN_MODE = 0;
  localparam int BTN_ACC  = 1;
  localparam int BTN_UP   = 2;
  localparam int BTN_DOWN = 3;

  logic [4:0] hour_r, al_hour_r, hour_nxt, al_hour_nxt;
  logic [5:0] min_r, sec_r, al_min_r, al_sec_r;
  logic [5:0] min_nxt, sec_nxt, al_min_nxt, al_sec_nxt;
  logic       al_en_r, guard_r, menu_r, al_en_nxt, guard_nxt, menu_nxt;
  logic [7:0] ring_cnt_r, ring_cnt_nxt, ring_sec_r;
  logic [1:0] field_r, field_nxt;
  logic [3:0] prev_btn_r, prev_btn_nxt;
  mode_t      mode_r, mode_mid, mode_nxt;

  logic [3:0] btn_now, btn_edge;
  logic       is_btn, menu_mid, edit_mode;

  function automatic logic [5:0] step_val(input logic [5:0] v, input logic [5:0] lim,
                                          input logic up);
    logic [5:0] inc;
    inc = v + 6'd1;
    if (up) begin
      return (inc >= lim || inc == 6'd0) ? 6'd0 : inc;
    end
    return (v == 6'd0) ? lim - 6'd1 : v - 6'd1;
  endfunction

  assign is_btn    = (item.command == CMD_BUTTONS);
  assign btn_now   = {item.btn_down, item.btn_up, item.btn_accept, item.btn_mode};
  assign btn_edge  = btn_now & ~prev_btn_r;
  assign edit_mode = (mode_r == MODE_SET_ALARM) || (mode_r == MODE_SET_TIME);
  assign menu_mid  = menu_r ^ ((mode_r == MODE_MENU) && btn_edge[BTN_UP])
                            ^ ((mode_r == MODE_MENU) && btn_edge[BTN_DOWN]);

  // Mode next: mode edge unless accept held, then accept edge on updated mode.
  always_comb begin
    mode_mid = mode_r;
    if (btn_edge[BTN_MODE] && !item.btn_accept) begin
      mode_mid = (mode_r != MODE_CLOCK) ? MODE_CLOCK : MODE_MENU;
    end
    mode_nxt = mode_mid;
    if (btn_edge[BTN_ACC]) begin
      unique case (mode_mid)
        MODE_MENU:      mode_nxt = menu_mid ? MODE_SET_TIME : MODE_SET_ALARM;
        MODE_SET_ALARM: begin
          if (item.btn_mode || field_r >= FIELD_SECONDS) begin
            mode_nxt = MODE_CLOCK;
          end
        end
        MODE_CLOCK:     mode_nxt = mode_mid;
        MODE_SET_TIME:  mode_nxt = mode_mid;
      endcase
    end
    if (!is_btn) begin
      mode_nxt = mode_r;
    end
  end

  // Datapath: time, alarm setting, guard, ring count, menu and field.
  always_comb begin
    logic       edit_go;
    logic       edit_up;
    logic [1:0] f;
    logic [2:0] fn;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    al_hour_nxt  = al_hour_r;
    al_min_nxt   = al_min_r;
    al_sec_nxt   = al_sec_r;
    al_en_nxt    = al_en_r;
    guard_nxt    = guard_r;
    ring_cnt_nxt = ring_cnt_r;
    menu_nxt     = menu_r;
    field_nxt    = field_r;
    prev_btn_nxt = prev_btn_r;
    edit_go      = 1'b0;
    edit_up      = 1'b0;
    f            = field_r;
    fn           = 3'd0;
    if (!is_btn) begin
      if (mode_r != MODE_SET_TIME) begin
        sec_nxt = sec_r + 6'd1;
        if (sec_nxt > SEC_MAX) begin
          sec_nxt = 6'd0;
          min_nxt = min_r + 6'd1;
        end
        if (min_nxt > MIN_MAX) begin
          min_nxt  = 6'd0;
          hour_nxt = hour_r + 5'd1;
        end
        if (hour_nxt > HOUR_MAX) begin
          hour_nxt = 5'd0;
          min_nxt  = 6'd0;
          sec_nxt  = 6'd0;
        end
        if (al_en_r && hour_nxt == al_hour_r && min_nxt == al_min_r
            && sec_nxt == al_sec_r) begin
          guard_nxt = 1'b0;
        end
        if (alarm_active(al_en_r, guard_nxt, hour_nxt, min_nxt, sec_nxt,
                         al_hour_r, al_min_r, al_sec_r)) begin
          ring_cnt_nxt = ring_cnt_r + 8'd1;
        end
        if (ring_cnt_nxt >= ring_sec_r) begin
          ring_cnt_nxt = 8'd0;
          al_en_nxt    = 1'b0;
        end
      end
    end else begin
      prev_btn_nxt = btn_now;
      menu_nxt     = menu_mid;
      // Up edit first, then down edit on top of it.
      for (int k = 0; k < 2; k++) begin
        edit_up = (k == 0);
        edit_go = edit_up ? btn_edge[BTN_UP] : btn_edge[BTN_DOWN];
        if (edit_go && edit_mode) begin
          if (mode_r == MODE_SET_ALARM) begin
            unique case (field_r)
              FIELD_HOURS:   al_hour_nxt = 5'(step_val({1'b0, al_hour_nxt}, HOUR_LIM, edit_up));
              FIELD_MINUTES: al_min_nxt  = step_val(al_min_nxt, MIN_LIM, edit_up);
              FIELD_SECONDS: al_sec_nxt  = step_val(al_sec_nxt, SEC_LIM, edit_up);
              FIELD_NONE:    al_sec_nxt  = al_sec_nxt;
            endcase
          end else begin
            unique case (field_r)
              FIELD_HOURS:   hour_nxt = 5'(step_val({1'b0, hour_nxt}, HOUR_LIM, edit_up));
              FIELD_MINUTES: min_nxt  = step_val(min_nxt, MIN_LIM, edit_up);
              FIELD_SECONDS: sec_nxt  = step_val(sec_nxt, SEC_LIM, edit_up);
              FIELD_NONE:    sec_nxt  = sec_nxt;
            endcase
          end
        end
      end
      if (btn_edge[BTN_ACC]) begin
        unique case (mode_mid)
          MODE_MENU: begin
            if (!menu_mid) begin
              field_nxt = FIELD_HOURS;
            end
          end
          MODE_SET_ALARM: begin
            if (item.btn_mode) begin
              al_en_nxt = 1'b0;
              f         = FIELD_HOURS;
            end
            if (f >= FIELD_SECONDS) begin
              field_nxt = FIELD_HOURS;
              al_en_nxt = 1'b1;
              if (al_hour_nxt <= hour_nxt || al_min_nxt <= min_nxt
                  || al_sec_nxt <= sec_nxt) begin
                guard_nxt = 1'b1;
              end
            end else begin
              field_nxt = f + 2'd1;
            end
          end
          MODE_SET_TIME: begin
            fn = {1'b0, field_r} + 3'd1;
            if (fn > 3'd2 && !item.btn_mode) begin
              fn = 3'd0;
            end
            field_nxt = fn[1:0];
          end
          MODE_CLOCK: begin
            if (alarm_active(al_en_nxt, guard_nxt, hour_nxt, min_nxt, sec_nxt,
                             al_hour_nxt, al_min_nxt, al_sec_nxt)) begin
              ring_cnt_nxt = 8'd0;
              al_en_nxt    = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // Snapshot of the state after this beat.
  always_comb begin
    snap_nxt.hours         = hour_nxt;
    snap_nxt.minutes       = min_nxt;
    snap_nxt.seconds       = sec_nxt;
    snap_nxt.alarm_hours   = al_hour_nxt;
    snap_nxt.alarm_minutes = al_min_nxt;
    snap_nxt.alarm_seconds = al_sec_nxt;
    snap_nxt.ui_mode       = mode_nxt;
    snap_nxt.menu_index    = menu_nxt;
    snap_nxt.edit_field    = field_nxt;
    snap_nxt.alarm_on      = al_en_nxt;
    snap_nxt.ringing       = alarm_active(al_en_nxt, guard_nxt, hour_nxt, min_nxt, sec_nxt,
                                          al_hour_nxt, al_min_nxt, al_sec_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r     <= 5'd0;
      min_r      <= 6'd0;
      sec_r      <= 6'd0;
      al_hour_r  <= 5'd0;
      al_min_r   <= 6'd0;
      al_sec_r   <= 6'd0;
      al_en_r    <= 1'b0;
      guard_r    <= 1'b0;
      ring_cnt_r <= 8'd0;
      mode_r     <= MODE_CLOCK;
      menu_r     <= 1'b0;
      field_r    <= FIELD_HOURS;
      prev_btn_r <= 4'd0;
    end else if (step) begin
      hour_r     <= hour_nxt;
      min_r      <= min_nxt;
      sec_r      <= sec_nxt;
      al_hour_r  <= al_hour_nxt;
      al_min_r   <= al_min_nxt;
      al_sec_r   <= al_sec_nxt;
      al_en_r    <= al_en_nxt;
      guard_r    <= guard_nxt;
      ring_cnt_r <= ring_cnt_nxt;
      mode_r     <= mode_nxt;
      menu_r     <= menu_nxt;
      field_r    <= field_nxt;
      prev_btn_r <= prev_btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_sec_r <= RING_SECONDS_RESET;
    end else if (cfg_we) begin
      ring_sec_r <= cfg_wdata;
    end
  end

  `ACBS_ASSERT(a_time_range, clk, rst_n, (hour_r <= HOUR_MAX) && (min_r <= MIN_MAX) && (sec_r <= SEC_MAX))
  `ACBS_ASSERT(a_alarm_range, clk, rst_n, (al_hour_r <= HOUR_MAX) && (al_min_r <= MIN_MAX) && (al_sec_r <= SEC_MAX))
  `ACBS_ASSERT(a_settime_holds, clk, rst_n, (step && !is_btn && mode_r == MODE_SET_TIME) |=> ($stable(sec_r) && $stable(min_r) && $stable(hour_r)))
  `ACBS_ASSERT(a_idle_holds, clk, rst_n, !step |=> ($stable(al_hour_r) && $stable(mode_r) && $stable(ring_cnt_r)))

endmodule

### sv/acbs_out_stage.sv
// Result register stage of the alarm clock block.
module acbs_out_stage import acbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      vld,
  input  out_item_t snap,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t data_r;

  assign take          = !out_valid_r || !out_stall;
  assign out_valid_nxt = take ? vld : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && vld) begin
      data_r <= snap;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = data_r;

endmodule

### sv/alarm_clock_with_button_setting_top.sv
// A beat accepted into the input register moves on to the result register, which raises out_valid.
// Throughput: one beat per cycle while out_stall is low; the state update is one pass of logic between the registers.
// A new input beat is taken while a finished result still waits in the result register, if the input register is empty.
// Reset (rst_n low at a rising edge, synchronous) clears time, alarm, menu and both stages.
// After reset ring_seconds holds 10 and cfg_ready is always high.
module alarm_clock_with_button_setting_top import acbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  // The input stage holds one beat; it advances whenever the result register can take it.
  logic      vld;
  logic      take;
  logic      step;
  in_item_t  item;
  out_item_t snap_nxt;

  // The state registers move exactly when a beat passes from the input stage to the result
  // register, so every beat updates the state once and yields exactly one result.
  assign step = vld && take;

  // The single configuration register can always be written.
  assign cfg_ready = 1'b1;

  acbs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .vld      (vld),
    .item     (item)
  );

  // The core computes the next state and the result snapshot from the held beat.
  acbs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .snap_nxt  (snap_nxt)
  );

  // The result register parts the output handshake from the input side.
  acbs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (vld),
    .snap      (snap_nxt),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
